[design/ssid_pkg.sv]
// ----------------------------------------------------------------------------
// ssid_pkg: shared types and constants of the sorted set
// Capacity, derived widths, status codes, command action codes and the
// control word that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package ssid_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int VAL_W    = 32;

    // status reported with every result item
    localparam logic [1:0] ST_CHANGED = 2'd0;
    localparam logic [1:0] ST_SAME    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // command action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CMP,
        OP_INS,
        OP_DEL
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [VAL_W-1:0]   key;
    } t_cell_ctl;

endpackage

[design/ssid_cell.sv]
// ----------------------------------------------------------------------------
// ssid_cell: one storage cell of the sorted chain
// Holds one value, compares it against the broadcast key and, on an
// update, keeps its value, takes the key or takes a neighbor's value.
// ----------------------------------------------------------------------------
module ssid_cell (
    input  logic                              i_clk,
    input  ssid_pkg::t_cell_ctl               i_ctl,
    input  logic                              i_occupied,
    input  logic                              i_prev_lt,
    input  logic signed [ssid_pkg::VAL_W-1:0] i_prev_val,
    input  logic signed [ssid_pkg::VAL_W-1:0] i_next_val,
    output logic signed [ssid_pkg::VAL_W-1:0] o_val,
    output logic                              o_lt,
    output logic                              o_eq
);
    import ssid_pkg::*;

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;
    logic                    r_lt;
    logic                    r_eq;

    // pick the next value from the broadcast operation
    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            OP_INS: begin
                if (!r_lt) begin
                    n_val = i_prev_lt ? i_ctl.key : i_prev_val;
                end
            end
            OP_DEL: begin
                if (!r_lt) begin
                    n_val = i_next_val;
                end
            end
            default: n_val = r_val;
        endcase
    end

    // register the next value, register compare flags on a compare
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_ctl.op == OP_CMP) begin
            r_lt <= i_occupied && (r_val < i_ctl.key);
            r_eq <= i_occupied && (r_val == i_ctl.key);
        end
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

[design/sorted_set_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_set_insert_delete: sorted set of distinct signed values
// Chain of storage cells kept in ascending order; insert or delete one
// value per command, then stream the whole set out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command item:
//   i_action (0 insert, 1 delete) and i_value. Output channel
//   (o_out_valid / i_out_stall) returns one result item per stored value
//   in ascending order, each with the count and status of the command;
//   o_last marks the final one. An empty set returns a single item with
//   o_has_element low.
//   Timing: after acceptance the compare state checks the key in every
//   cell at once, the update state shifts the chain, then results leave
//   at one per cycle from the output register while the receiver does
//   not stall. The result rate of one item per cycle is set by the
//   single output port.
//   o_in_stall is high while a command is in progress; the next command
//   is taken while the final result still waits in the output register.
//   A receiver stall holds the output register and pauses the stream.
//   Reset empties the set and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_set_insert_delete (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic signed [ssid_pkg::VAL_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ssid_pkg::CNT_W-1:0]        o_count,
    output logic signed [ssid_pkg::VAL_W-1:0] o_element,
    output logic                              o_has_element,
    output logic [1:0]                        o_status,
    output logic                              o_last
);
    import ssid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic                    r_action;
    logic signed [VAL_W-1:0] r_key;
    logic [CNT_W-1:0]        r_size;
    logic [1:0]              r_status;
    logic [IDX_W-1:0]        r_idx;

    logic                    r_out_valid;
    logic [CNT_W-1:0]        r_out_count;
    logic signed [VAL_W-1:0] r_out_element;
    logic                    r_out_has;
    logic [1:0]              r_out_status;
    logic                    r_out_last;

    t_cell_ctl               w_ctl;
    logic signed [VAL_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_eq;
    logic                    w_found;
    logic                    w_full;
    logic                    w_accept;
    logic                    w_load;
    logic                    w_is_last;

    assign w_found   = |w_eq;
    assign w_full    = (r_size == CNT_W'(CAPACITY));
    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign w_is_last = (r_size == '0) || (CNT_W'(r_idx) == r_size - CNT_W'(1));

    // broadcast control to the chain
    always_comb begin
        w_ctl.key = r_key;
        w_ctl.op  = OP_HOLD;
        case (r_state)
            S_CMP: w_ctl.op = OP_CMP;
            S_UPD: begin
                if (r_action == ACT_INSERT && !w_found && !w_full) begin
                    w_ctl.op = OP_INS;
                end else if (r_action == ACT_DELETE && w_found) begin
                    w_ctl.op = OP_DEL;
                end
            end
            default: w_ctl.op = OP_HOLD;
        endcase
    end

    // build the chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    w_prev_lt;
        logic signed [VAL_W-1:0] w_prev_val;
        logic signed [VAL_W-1:0] w_next_val;

        if (g == 0) begin : g_head
            assign w_prev_lt  = 1'b1;
            assign w_prev_val = r_key;
        end else begin : g_body
            assign w_prev_lt  = w_lt[g-1];
            assign w_prev_val = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_val = w_val[g];
        end else begin : g_inner
            assign w_next_val = w_val[g+1];
        end

        ssid_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (CNT_W'(g) < r_size),
            .i_prev_lt  (w_prev_lt),
            .i_prev_val (w_prev_val),
            .i_next_val (w_next_val),
            .o_val      (w_val[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );
    end

    // sequence commands and drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_action <= i_action;
                        r_key    <= i_value;
                        r_state  <= S_CMP;
                    end
                end
                S_CMP: r_state <= S_UPD;
                S_UPD: begin
                    r_idx <= '0;
                    case (w_ctl.op)
                        OP_INS: begin
                            r_size   <= r_size + CNT_W'(1);
                            r_status <= ST_CHANGED;
                        end
                        OP_DEL: begin
                            r_size   <= r_size - CNT_W'(1);
                            r_status <= ST_CHANGED;
                        end
                        default: begin
                            r_status <= (r_action == ACT_INSERT && !w_found && w_full)
                                        ? ST_FULL : ST_SAME;
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_out_valid   <= 1'b1;
                        r_out_count   <= r_size;
                        r_out_element <= (r_size == '0) ? '0 : w_val[r_idx];
                        r_out_has     <= (r_size != '0);
                        r_out_status  <= r_status;
                        r_out_last    <= w_is_last;
                        r_idx         <= r_idx + IDX_W'(1);
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_count       = r_out_count;
    assign o_element     = r_out_element;
    assign o_has_element = r_out_has;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

endmodule

[design/ssid_checker.sv]
// ----------------------------------------------------------------------------
// ssid_checker: port-level checks of the sorted set
// Watches the top level's channels and flags stream and status slips.
// ----------------------------------------------------------------------------
module ssid_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [ssid_pkg::CNT_W-1:0]        o_count,
    input logic signed [ssid_pkg::VAL_W-1:0] o_element,
    input logic                              o_has_element,
    input logic [1:0]                        o_status,
    input logic                              o_last
);
    import ssid_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_element)
            && $stable(o_last) && $stable(o_count))
        else $error("stalled result item changed");

    // an accepted command blocks the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("command taken while busy");

    // an empty set gives one final item with count zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_element |-> o_last && (o_count == '0))
        else $error("empty-set item malformed");

    // count never exceeds capacity and status is a known code
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count <= CNT_W'(CAPACITY))
            && (o_status == ST_CHANGED || o_status == ST_SAME || o_status == ST_FULL))
        else $error("count or status out of range");

endmodule

bind sorted_set_insert_delete ssid_checker u_ssid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_count       (o_count),
    .o_element     (o_element),
    .o_has_element (o_has_element),
    .o_status      (o_status),
    .o_last        (o_last)
);
